// File: hw/rtl/itoa_pkg.sv
package itoa_pkg;

    // width of the integer that is converted (8 to 64)
    localparam int VALUE_WIDTH  = 64;
    // width of the value field on the input port
    localparam int IN_WIDTH     = 64;

    // decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
    localparam int DIGIT_COUNT  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH    = 4 * DIGIT_COUNT;
    localparam int BIT_CNT_W    = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W    = $clog2(DIGIT_COUNT + 1);

    // front to back queue
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // ascii codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    localparam logic [3:0] DEC_BASE   = 4'd10;

    // one classified word waiting for conversion
    typedef struct packed {
        logic                   hex;
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic idle;
        logic pop;
    } back_stat_t;

    // digit value to ascii, upper case hex letters
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d >= DEC_BASE)
        begin
            return CH_UPPER_A + {4'd0, d - DEC_BASE};
        end
        return CH_ZERO + {4'd0, d};
    endfunction

endpackage

// File: hw/rtl/integer_to_ascii_text_top.sv
// channel   dir  handshake              payload
// s_axis    in   tvalid / tready        tdata = value (64), tuser = mode (1)
// m_axis    out  tvalid / tready        tdata = ch (8), tlast = last
//
// decimal: a load, shift-and-add-3 bcd conversion over every magnitude bit, leading zero digits
//   skipped, then the sign word (negative only) and the digit words; hex: a load, leading zero digits
//   skipped, then the digit words, with no sign
// a two-entry queue lets the input side keep accepting while conversion runs
// rst_n clears the queue, the sequencer and the output valid at once
// a stalled m_axis holds the output register and the sequencer waits on it before a sign or digit word
module integer_to_ascii_text_top
    import itoa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_WIDTH-1:0] s_axis_tdata,   // [63:0] value
    input  logic                s_axis_tuser,   // [0] mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] ch
    output logic                m_axis_tlast
);

    q_stat_t    q_stat;
    back_stat_t b_stat;
    item_t      wr_item;
    item_t      rd_item;
    logic       push;

    // accept and classify
    itoa_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .mode     (s_axis_tuser),
        .value    (s_axis_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .item     (wr_item)
    );

    // decoupling queue
    itoa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (b_stat.pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    // conversion and character output
    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_item   (rd_item),
        .stat      (b_stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ch    (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // queue fill never passes its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // an idle back end picks up a waiting word at once
    a_back_pickup: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.idle && !q_stat.empty |=> !b_stat.idle)
        else $error("back end idle with a word waiting");

    // only digits, upper case hex letters or a minus sign go out
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE) ||
             (m_axis_tdata >= CH_UPPER_A && m_axis_tdata <= CH_UPPER_F) ||
             (m_axis_tdata == CH_MINUS)))
        else $error("character outside the output set");

    // a minus sign is never the end of the text
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata == CH_MINUS) |-> !m_axis_tlast)
        else $error("minus sign flagged as last");

endmodule

// File: hw/rtl/itoa_front.sv
module itoa_front
    import itoa_pkg::*;
(
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [IN_WIDTH-1:0] value,
    input  q_stat_t             q_stat,
    output logic                push,
    output item_t               item
);

    logic [VALUE_WIDTH-1:0] masked;
    logic                   neg;

    // take a word whenever the queue has room
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    // drop bits above the value width, fold a negative decimal to its magnitude
    assign masked   = value[VALUE_WIDTH-1:0];
    assign neg      = !mode && masked[VALUE_WIDTH-1];

    always_comb
    begin
        item.hex = mode;
        item.neg = neg;
        item.mag = neg ? ('0 - masked) : masked;
    end

endmodule

// File: hw/rtl/itoa_queue.sv
module itoa_queue
    import itoa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   wr_item,
    input  logic    pop,
    output item_t   rd_item,
    output q_stat_t stat
);

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item    = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

// File: hw/rtl/itoa_back.sv
module itoa_back
    import itoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    input  item_t      rd_item,
    output back_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_ch,
    output logic       out_last
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_CONV = 5'b00010,
        B_SKIP = 5'b00100,
        B_SIGN = 5'b01000,
        B_EMIT = 5'b10000
    } back_state_t;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   rem_reg;
    logic [DIG_CNT_W-1:0]   rem_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_ch_reg;
    logic [7:0]             out_ch_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic [BCD_WIDTH-1:0]   adj;
    logic [BCD_WIDTH-1:0]   dabble;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   pop;

    // add-3 correction on every bcd digit, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
        dabble = {adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];
    assign out_free  = !out_valid_reg || out_ready;

    // sequencer: load, convert (decimal only), skip leading zeros, sign (negative only), digits
    always_comb
    begin
        state_next     = state_reg;
        bcd_next       = bcd_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ch_next    = out_ch_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    neg_next = rd_item.neg;
                    rem_next = DIG_CNT_W'(DIGIT_COUNT);
                    if (rd_item.hex)
                    begin
                        bcd_next   = BCD_WIDTH'(rd_item.mag);
                        state_next = B_SKIP;
                    end
                    else
                    begin
                        bcd_next     = '0;
                        mag_next     = rd_item.mag;
                        bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                        state_next   = B_CONV;
                    end
                end
            end
            B_CONV:
            begin
                bcd_next     = dabble;
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = B_SKIP;
                end
            end
            B_SKIP:
            begin
                if (top_digit == 4'd0 && rem_reg > DIG_CNT_W'(1))
                begin
                    bcd_next = bcd_reg << 4;
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? B_SIGN : B_EMIT;
                end
            end
            B_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = CH_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = digit_char(top_digit);
                    out_last_next  = (rem_reg == DIG_CNT_W'(1));
                    bcd_next       = bcd_reg << 4;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == DIG_CNT_W'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output data
    always_ff @(posedge clk)
    begin
        bcd_reg      <= bcd_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bit_cnt_reg  <= bit_cnt_next;
        rem_reg      <= rem_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ch    = out_ch_reg;
    assign out_last  = out_last_reg;
    assign stat.idle = (state_reg == B_IDLE);
    assign stat.pop  = pop;

endmodule

// File: verif/integer_to_ascii_text_top_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_text_top_tb
    import itoa_pkg::*;
();

    localparam logic MODE_DEC      = 1'b0;
    localparam logic MODE_HEX      = 1'b1;
    localparam int   MAX_CHARS     = 20;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   DRAIN_CYCLES  = 200;
    localparam int   RANDOM_ITEMS  = 480;
    localparam int   HOLD_START    = 2000;
    localparam int   HOLD_CYCLES   = 3000;
    localparam int   REPORT_LIMIT  = 10;

    typedef enum logic [1:0]
    {
        RX_ALWAYS,
        RX_HALF,
        RX_MOSTLY,
        RX_PATTERN
    } rx_mode_t;

    typedef struct
    {
        logic                mode;
        logic [IN_WIDTH-1:0] value;
    } conv_req_t;

    typedef struct
    {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_WIDTH-1:0] s_axis_tdata = '0;    // [63:0] value
    logic                s_axis_tuser = 1'b0;  // [0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;         // [7:0] ch
    logic                m_axis_tlast;

    conv_req_t  pending_reqs[$];
    text_char_t expected_text[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         hold_timer = 0;
    int         hold_left = 0;
    rx_mode_t   rx_mode = RX_ALWAYS;
    int         rx_phase_left = 0;
    logic [7:0] rx_pattern = 8'hFF;

    integer_to_ascii_text_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // expected text of one word: sign, then digits without leading zeros
    function automatic void predict_text(input logic mode, input logic [IN_WIDTH-1:0] raw);
        longint unsigned width_mask;
        longint unsigned mag;
        longint unsigned base;
        logic [3:0]      digits[MAX_CHARS];
        int              n_digits;
        logic [7:0]      text[$];
        logic            neg;
        text_char_t      item;
        width_mask = (VALUE_WIDTH == 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 1);
        mag = raw & width_mask;
        neg = 1'b0;
        if (mode == MODE_DEC && mag[VALUE_WIDTH-1])
        begin
            neg = 1'b1;
            mag = (64'd0 - mag) & width_mask;
        end
        base = (mode == MODE_HEX) ? 16 : 10;
        n_digits = 0;
        do
        begin
            if (n_digits < MAX_CHARS)
            begin
                digits[n_digits] = 4'(mag % base);
                n_digits++;
            end
            mag = mag / base;
        end
        while (mag != 0);
        if (neg)
            text.push_back(CH_MINUS);
        for (int k = n_digits - 1; k >= 0 && text.size() < MAX_CHARS; k--)
        begin
            if (digits[k] >= DEC_BASE)
                text.push_back(CH_UPPER_A + 8'(digits[k] - DEC_BASE));
            else
                text.push_back(CH_ZERO + 8'(digits[k]));
        end
        foreach (text[i])
        begin
            item.ch = text[i];
            item.last = (i == text.size() - 1);
            expected_text.push_back(item);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic queue_item(input logic mode, input logic [IN_WIDTH-1:0] value);
        conv_req_t req;
        req.mode = mode;
        req.value = value;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sender: bursts of words with random gaps, valid held until accepted
    always @(posedge clk)
    begin
        logic offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text(pending_reqs[0].mode, pending_reqs[0].value);
                void'(pending_reqs.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
                end
            end
            if (s_axis_tvalid && !s_axis_tready)
                offer = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_reqs.size() > 0)
                offer = 1'b1;
            s_axis_tvalid <= offer;
            if (offer)
            begin
                s_axis_tdata <= pending_reqs[0].value;
                s_axis_tuser <= pending_reqs[0].mode;
            end
        end
    end

    // one long receiver hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            hold_timer <= hold_timer + 1;
            if (hold_timer == HOLD_START)
                hold_left <= HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // receiver: stall behavior changes phase by phase
    always @(posedge clk)
    begin
        logic ready_next;
        ready_next = 1'b1;
        if (rst_n)
        begin
            if (rx_phase_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(50, 400);
                rx_pattern = 8'($urandom);
            end
            else
                rx_phase_left--;
            case (rx_mode)
                RX_ALWAYS:  ready_next = 1'b1;
                RX_HALF:    ready_next = 1'($urandom_range(0, 1));
                RX_MOSTLY:  ready_next = ($urandom_range(0, 9) != 0);
                default:
                begin
                    ready_next = rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
            m_axis_tready <= ready_next && (hold_left == 0);
        end
    end

    // monitor: compare each output word with the oldest expected character
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_text.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word ch=%02h last=%0d",
                                        m_axis_tdata, m_axis_tlast));
            end
            else
            begin
                want = expected_text.pop_front();
                if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                    note_mismatch($sformatf(
                        "mismatch: expected ch=%02h last=%0d, got ch=%02h last=%0d",
                        want.ch, want.last, m_axis_tdata, m_axis_tlast));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL integer_to_ascii_text_top");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [63:0]     top_bit;
        logic [63:0]     width_mask;
        logic [63:0]     value;
        logic [63:0]     pow10[20];
        logic            mode;
        int              sel;
        int              k;
        top_bit = 64'd1 << (VALUE_WIDTH - 1);
        width_mask = (VALUE_WIDTH == 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 1);
        pow10[0] = 64'd1;
        for (int i = 1; i < 20; i++)
            pow10[i] = pow10[i-1] * 64'd10;

        // zero, one, extremes of both modes, most negative, hex letters
        queue_item(MODE_DEC, 64'd0);
        queue_item(MODE_HEX, 64'd0);
        queue_item(MODE_DEC, 64'd1);
        queue_item(MODE_DEC, width_mask);
        queue_item(MODE_HEX, width_mask);
        queue_item(MODE_DEC, top_bit);
        queue_item(MODE_HEX, top_bit);
        queue_item(MODE_DEC, top_bit - 1);
        queue_item(MODE_DEC, top_bit + 1);
        queue_item(MODE_HEX, 64'd9);
        queue_item(MODE_HEX, 64'd10);
        queue_item(MODE_HEX, 64'd15);
        queue_item(MODE_HEX, 64'd16);
        queue_item(MODE_DEC, 64'd9);
        queue_item(MODE_DEC, 64'd10);
        queue_item(MODE_DEC, 64'd0 - 64'd10);
        queue_item(MODE_HEX, 64'h0123_4567_89AB_CDEF);
        queue_item(MODE_HEX, 64'hFEDC_BA98_7654_3210);
        queue_item(MODE_DEC, 64'hFEDC_BA98_7654_3210);
        queue_item(MODE_DEC, 64'd9999999999999999999);
        queue_item(MODE_DEC, pow10[18]);
        // bits above the value width are ignored; at a value width of 64 there are none to drop
        queue_item(MODE_DEC, 64'hFFFF_FFFF_FFFF_FF00);
        queue_item(MODE_HEX, 64'hA5A5_5A5A_0000_0001);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mode = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            k = $urandom_range(0, 63);
            if (sel < 30)
                value = rand64();
            else if (sel < 55)
                value = rand64() >> k;
            else if (sel < 75)
                value = 64'd0 - (rand64() >> k);
            else if (sel < 90)
                value = pow10[$urandom_range(0, 19)] + 64'($urandom_range(0, 2)) - 64'd1;
            else
                value = (64'd1 << k) - 64'($urandom_range(0, 1));
            queue_item(mode, value);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
            $display("PASS integer_to_ascii_text_top");
        else
            $display("FAIL integer_to_ascii_text_top");
        $finish;
    end

endmodule
